>>> hw/rtl/router_output_queue_switch_stage_macros.svh
// Assertion macros shared by the router output queue RTL.
`ifndef ROUTER_OUTPUT_QUEUE_SWITCH_STAGE_MACROS_SVH
`define ROUTER_OUTPUT_QUEUE_SWITCH_STAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ROSW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in router output queue");

// The consequent must hold in the cycle after the antecedent.
`define ROSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in router output queue");

`endif

>>> hw/rtl/rosw_pkg.sv
// Types and constants of the router output queue with switch allocation stage.
`default_nettype none

package rosw_pkg;

   localparam int FLIT_BITS  = 64;
   localparam int LIMIT_BITS = 5;
   localparam int OCC_BITS   = 5;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [1:0] {
      FUNC_ARRIVE   = 2'd0,
      FUNC_RESPONSE = 2'd1,
      FUNC_TICK     = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STAGE_EMPTY      = 2'd0,
      STAGE_TO_REQUEST = 2'd1,
      STAGE_WAIT_RESP  = 2'd2,
      STAGE_READY      = 2'd3
   } stage_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_type;

   typedef struct packed {
      logic [1:0]           func;
      logic [FLIT_BITS-1:0] flit_data;
      logic                 granted;
   } req_type;

   typedef struct packed {
      logic                 send_valid;
      logic [FLIT_BITS-1:0] send_flit;
      logic                 request_valid;
      logic [FLIT_BITS-1:0] request_flit;
      logic                 credit_return;
      logic                 overflow;
      logic                 bad_response;
      logic [OCC_BITS-1:0]  occupancy;
      logic [1:0]           stage_status;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/router_output_queue_switch_stage.sv
// Router output queue: flit FIFO in a synchronous memory and a one-entry switch stage.
// Flow: an accepted request is registered in req_ff, the sequencer executes it, and the
// result and its strobe are registered in rsp_item_ff and rsp_strobe_ff.
// A new item is not taken while one executes: busy is high in the execute state.
// The receiver cannot stall, so results never wait and busy depends only on the sequencer.
// Reset clears pointers, fill count, stage state and sets the limit to 16.
// The queue memory is not cleared; read data is used only from entries that have been written.
`default_nettype none

`include "router_output_queue_switch_stage_macros.svh"

module router_output_queue_switch_stage #(
   parameter int QUEUE_DEPTH = 16,
   parameter int FLIT_WIDTH  = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [rosw_pkg::LIMIT_BITS-1:0]       csr_wdata,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire rosw_pkg::req_type                     req_item,
   output logic                                       rsp_strobe,
   output rosw_pkg::rsp_type                          rsp_item
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = (CW > rosw_pkg::LIMIT_BITS) ? CW : rosw_pkg::LIMIT_BITS;
   localparam logic [IW-1:0] LAST_INDEX = IW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   rosw_pkg::ctl_type               ctl_ff, ctl_in;
   rosw_pkg::stage_type             stage_ff, stage_in;
   logic [IW-1:0]                   head_ff, head_in;
   logic [IW-1:0]                   tail_ff, tail_in;
   logic [CW-1:0]                   fill_ff, fill_in;
   logic [FLIT_WIDTH-1:0]           stage_flit_ff, stage_flit_in;
   logic [rosw_pkg::LIMIT_BITS-1:0] limit_ff;
   rosw_pkg::req_type               req_ff;
   logic [FLIT_WIDTH-1:0]           rd_data_ff;
   logic                            rsp_strobe_ff;
   rosw_pkg::rsp_type               rsp_item_ff, rsp_item_in;
   logic                            accept;
   logic                            exec;
   logic                            wr_en;
   logic                            at_limit;

   logic [FLIT_WIDTH-1:0] queue_mem [QUEUE_DEPTH];

   assign busy   = (ctl_ff == rosw_pkg::CTL_EXEC);
   assign accept = start && !busy;
   assign exec   = (ctl_ff == rosw_pkg::CTL_EXEC);

   always_comb begin
      ctl_in = ctl_ff;
      case (ctl_ff)
         rosw_pkg::CTL_IDLE: begin
            if (accept) begin
               ctl_in = rosw_pkg::CTL_EXEC;
            end
         end
         rosw_pkg::CTL_EXEC: begin
            ctl_in = rosw_pkg::CTL_IDLE;
         end
         default: begin
            ctl_in = rosw_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= rosw_pkg::CTL_IDLE;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign at_limit = (LW'(fill_ff) >= LW'(limit_ff)) || (fill_ff == FULL_COUNT);

   always_comb begin
      stage_in      = stage_ff;
      stage_flit_in = stage_flit_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      wr_en         = 1'b0;
      rsp_item_in   = '0;
      if (exec) begin
         case (rosw_pkg::func_type'(req_ff.func))
            rosw_pkg::FUNC_ARRIVE: begin
               if (at_limit) begin
                  rsp_item_in.overflow = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  tail_in = (tail_ff == LAST_INDEX) ? '0 : tail_ff + IW'(1);
                  fill_in = fill_ff + CW'(1);
               end
            end
            rosw_pkg::FUNC_RESPONSE: begin
               if (stage_ff != rosw_pkg::STAGE_WAIT_RESP) begin
                  rsp_item_in.bad_response = 1'b1;
               end else if (req_ff.granted) begin
                  stage_in = rosw_pkg::STAGE_READY;
               end else begin
                  stage_in = rosw_pkg::STAGE_TO_REQUEST;
               end
            end
            rosw_pkg::FUNC_TICK: begin
               if (stage_in == rosw_pkg::STAGE_READY) begin
                  rsp_item_in.send_valid = 1'b1;
                  rsp_item_in.send_flit  = rosw_pkg::FLIT_BITS'(stage_flit_ff);
                  stage_in               = rosw_pkg::STAGE_EMPTY;
               end
               if ((stage_in == rosw_pkg::STAGE_EMPTY) && (fill_ff != '0)) begin
                  stage_flit_in             = rd_data_ff;
                  head_in                   = (head_ff == LAST_INDEX) ? '0 : head_ff + IW'(1);
                  fill_in                   = fill_ff - CW'(1);
                  rsp_item_in.credit_return = 1'b1;
                  stage_in                  = rosw_pkg::STAGE_TO_REQUEST;
               end
               if (stage_in == rosw_pkg::STAGE_TO_REQUEST) begin
                  rsp_item_in.request_valid = 1'b1;
                  rsp_item_in.request_flit  = rosw_pkg::FLIT_BITS'(stage_flit_in);
                  stage_in                  = rosw_pkg::STAGE_WAIT_RESP;
               end
            end
            default: begin
            end
         endcase
         rsp_item_in.occupancy    = rosw_pkg::OCC_BITS'(fill_in);
         rsp_item_in.stage_status = stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= rosw_pkg::STAGE_EMPTY;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         limit_ff      <= rosw_pkg::LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         stage_ff      <= stage_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= exec;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_flit_ff <= stage_flit_in;
      rsp_item_ff   <= rsp_item_in;
      if (accept) begin
         req_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[tail_ff] <= req_ff.flit_data[FLIT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= queue_mem[head_ff];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `ROSW_ASSERT_NEXT(a_exec_gives_result, clock, reset, exec, rsp_strobe_ff)
   `ROSW_ASSERT_SAME(a_no_write_when_full, clock, reset, wr_en, fill_ff != FULL_COUNT)
   `ROSW_ASSERT_SAME(a_credit_pops_one, clock, reset,
      rsp_strobe_ff && rsp_item_ff.credit_return, fill_ff == $past(fill_ff) - CW'(1))
   `ROSW_ASSERT_SAME(a_send_from_ready, clock, reset,
      rsp_strobe_ff && rsp_item_ff.send_valid, $past(stage_ff) == rosw_pkg::STAGE_READY)

endmodule

`default_nettype wire

>>> bench/router_queue_checker.sv
// Checker for the router output queue: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module router_queue_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [rosw_pkg::LIMIT_BITS-1:0] csr_wdata,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire rosw_pkg::req_type               req_item,
   input  wire logic                            rsp_strobe,
   input  wire rosw_pkg::rsp_type               rsp_item,
   output int                                   fail_count,
   output int                                   pending
);

   localparam int DEPTH = 16;

   logic [rosw_pkg::FLIT_BITS-1:0]  flit_store [DEPTH];
   logic [3:0]                      head_ptr;
   logic [3:0]                      tail_ptr;
   logic [rosw_pkg::OCC_BITS-1:0]   fill;
   rosw_pkg::stage_type             stage;
   logic [rosw_pkg::FLIT_BITS-1:0]  stage_flit;
   logic [rosw_pkg::LIMIT_BITS-1:0] queue_limit;
   rosw_pkg::rsp_type               expected_rsp [$];
   int                              rsp_number;

   task automatic report(input string msg);
      $display("%0t ns: result %0d: %s", $time, rsp_number, msg);
      fail_count++;
   endtask

   function automatic rosw_pkg::rsp_type queue_step(input rosw_pkg::req_type r);
      rosw_pkg::rsp_type             o;
      logic [rosw_pkg::OCC_BITS-1:0] cap;
      o   = '0;
      cap = (queue_limit > DEPTH) ? rosw_pkg::OCC_BITS'(DEPTH) : queue_limit;
      case (r.func)
         rosw_pkg::FUNC_ARRIVE: begin
            if (fill >= cap) begin
               o.overflow = 1'b1;
            end else begin
               flit_store[tail_ptr] = r.flit_data;
               tail_ptr++;
               fill++;
            end
         end
         rosw_pkg::FUNC_RESPONSE: begin
            if (stage != rosw_pkg::STAGE_WAIT_RESP) begin
               o.bad_response = 1'b1;
            end else begin
               stage = r.granted ? rosw_pkg::STAGE_READY : rosw_pkg::STAGE_TO_REQUEST;
            end
         end
         rosw_pkg::FUNC_TICK: begin
            if (stage == rosw_pkg::STAGE_READY) begin
               o.send_valid = 1'b1;
               o.send_flit  = stage_flit;
               stage        = rosw_pkg::STAGE_EMPTY;
               stage_flit   = '0;
            end
            if (stage == rosw_pkg::STAGE_EMPTY && fill > 0) begin
               stage_flit      = flit_store[head_ptr];
               head_ptr++;
               fill--;
               o.credit_return = 1'b1;
               stage           = rosw_pkg::STAGE_TO_REQUEST;
            end
            if (stage == rosw_pkg::STAGE_TO_REQUEST) begin
               o.request_valid = 1'b1;
               o.request_flit  = stage_flit;
               stage           = rosw_pkg::STAGE_WAIT_RESP;
            end
         end
         default: begin
         end
      endcase
      o.occupancy    = fill;
      o.stage_status = stage;
      return o;
   endfunction

   always @(posedge clock) begin
      rosw_pkg::rsp_type want;
      if (reset) begin
         head_ptr    = '0;
         tail_ptr    = '0;
         fill        = '0;
         stage       = rosw_pkg::STAGE_EMPTY;
         stage_flit  = '0;
         queue_limit = rosw_pkg::LIMIT_RESET;
         fail_count  = 0;
         rsp_number  = 0;
         expected_rsp.delete();
      end else begin
         if (csr_we) begin
            queue_limit = csr_wdata;
         end
         if (start && !busy) begin
            expected_rsp.push_back(queue_step(req_item));
         end
         if (rsp_strobe) begin
            rsp_number++;
            if (expected_rsp.size() == 0) begin
               report("result arrived with no item outstanding");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_item.send_valid !== want.send_valid)
                  report($sformatf("send_valid %b, expected %b",
                                   rsp_item.send_valid, want.send_valid));
               if (rsp_item.send_flit !== want.send_flit)
                  report($sformatf("send_flit %h, expected %h",
                                   rsp_item.send_flit, want.send_flit));
               if (rsp_item.request_valid !== want.request_valid)
                  report($sformatf("request_valid %b, expected %b",
                                   rsp_item.request_valid, want.request_valid));
               if (rsp_item.request_flit !== want.request_flit)
                  report($sformatf("request_flit %h, expected %h",
                                   rsp_item.request_flit, want.request_flit));
               if (rsp_item.credit_return !== want.credit_return)
                  report($sformatf("credit_return %b, expected %b",
                                   rsp_item.credit_return, want.credit_return));
               if (rsp_item.overflow !== want.overflow)
                  report($sformatf("overflow %b, expected %b",
                                   rsp_item.overflow, want.overflow));
               if (rsp_item.bad_response !== want.bad_response)
                  report($sformatf("bad_response %b, expected %b",
                                   rsp_item.bad_response, want.bad_response));
               if (rsp_item.occupancy !== want.occupancy)
                  report($sformatf("occupancy %0d, expected %0d",
                                   rsp_item.occupancy, want.occupancy));
               if (rsp_item.stage_status !== want.stage_status)
                  report($sformatf("stage_status %0d, expected %0d",
                                   rsp_item.stage_status, want.stage_status));
            end
         end
      end
      pending <= expected_rsp.size();
   end

endmodule

>>> bench/tb.sv
// Testbench top for the router output queue: drives items and limits and gives the verdict.
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 68;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            csr_we    = 1'b0;
   logic [rosw_pkg::LIMIT_BITS-1:0] csr_wdata = '0;
   logic                            start     = 1'b0;
   rosw_pkg::req_type               req_item  = '0;
   logic                            busy;
   logic                            rsp_strobe;
   rosw_pkg::rsp_type               rsp_item;
   int                              fail_count;
   int                              pending;
   int                              cycles    = 0;
   bit                              gaps_on   = 1'b1;

   int phase_limit  [PHASES] = '{2, 16, 1, 31, 0, 7, 16, 3};
   int phase_arrive [PHASES] = '{50, 60, 40, 55, 30, 45, 20, 50};
   bit phase_gaps   [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};

   router_output_queue_switch_stage dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   router_queue_checker chk (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[router_output_queue_switch_stage] ERROR");
         $finish;
      end
   end

   task automatic send(input logic [1:0] f, input logic [rosw_pkg::FLIT_BITS-1:0] d,
                       input logic g);
      rosw_pkg::req_type r;
      r.func      = f;
      r.flit_data = d;
      r.granted   = g;
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_limit(input logic [rosw_pkg::LIMIT_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int n;
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(rosw_pkg::FUNC_RESPONSE, '0, 1'b1);
      send(FUNC_UNUSED, '1, 1'b1);
      send(rosw_pkg::FUNC_TICK, '0, 1'b0);
      send(rosw_pkg::FUNC_ARRIVE, '0, 1'b0);
      send(rosw_pkg::FUNC_ARRIVE, '1, 1'b0);
      send(rosw_pkg::FUNC_ARRIVE, 64'h8000_0000_0000_0001, 1'b0);
      send(rosw_pkg::FUNC_TICK, '0, 1'b0);
      send(rosw_pkg::FUNC_TICK, '0, 1'b0);
      send(rosw_pkg::FUNC_RESPONSE, '0, 1'b0);
      send(rosw_pkg::FUNC_RESPONSE, '0, 1'b1);
      send(rosw_pkg::FUNC_TICK, '0, 1'b0);
      send(rosw_pkg::FUNC_RESPONSE, '0, 1'b1);
      send(rosw_pkg::FUNC_RESPONSE, '0, 1'b1);
      send(rosw_pkg::FUNC_TICK, '0, 1'b0);
      send(rosw_pkg::FUNC_RESPONSE, '0, 1'b1);
      send(rosw_pkg::FUNC_TICK, '1, 1'b1);
      send(rosw_pkg::FUNC_ARRIVE, 64'h5555_5555_5555_5555, 1'b0);
      send(rosw_pkg::FUNC_ARRIVE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send(rosw_pkg::FUNC_ARRIVE, {$urandom, $urandom}, 1'b0);
      send(rosw_pkg::FUNC_ARRIVE, {$urandom, $urandom}, 1'b1);
      send(rosw_pkg::FUNC_ARRIVE, {$urandom, $urandom}, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_limit(rosw_pkg::LIMIT_BITS'(phase_limit[p]));
         gaps_on = phase_gaps[p];
         n = 0;
         while (n < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < phase_arrive[p]) begin
               send(rosw_pkg::FUNC_ARRIVE, {$urandom, $urandom}, 1'($urandom));
               n++;
            end else if (pick < 90) begin
               send(rosw_pkg::FUNC_TICK, {$urandom, $urandom}, 1'($urandom));
               send(rosw_pkg::FUNC_RESPONSE, {$urandom, $urandom},
                    $urandom_range(0, 99) < 65);
               n += 2;
            end else begin
               send(2'($urandom_range(0, 3)), {$urandom, $urandom}, 1'($urandom));
               n++;
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("[router_output_queue_switch_stage] OK");
      end else begin
         $display("[router_output_queue_switch_stage] ERROR");
      end
      $finish;
   end

endmodule

>>> router_output_queue_switch_stage.f
+incdir+hw/rtl
hw/rtl/rosw_pkg.sv
hw/rtl/router_output_queue_switch_stage.sv
bench/router_queue_checker.sv
bench/tb.sv
